/* hw/rtl/cmm_pkg.sv */
// ----------------------------------------------------------------------------
// cmm_pkg
// Shared types, codes and rounding for the complex matrix multiplier.
// ----------------------------------------------------------------------------
package cmm_pkg;

    localparam int DATA_W    = 20;
    localparam int NORM_W    = 16;
    localparam int FIELD_W   = 3;
    localparam int FUNC_W    = 2;
    localparam int QC_W      = 2;
    localparam int MUL_W     = 21;
    localparam int PROD_W    = 2 * MUL_W;
    localparam int ACC_W     = 48;
    localparam int FRAC_BITS = 14;

    localparam logic [FUNC_W-1:0] FUNC_LOAD_L  = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LOAD_R  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_COMPUTE = 2'd2;

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1 << (FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] SAT_HI     = ACC_W'(524287);
    localparam logic signed [ACC_W-1:0] SAT_LO     = ACC_W'(-524288);
    localparam logic [NORM_W-1:0]       NORM_MAX   = '1;

    typedef struct packed {
        logic [FUNC_W-1:0]        func;
        logic [FIELD_W-1:0]       row;
        logic [FIELD_W-1:0]       col;
        logic signed [DATA_W-1:0] value_re;
        logic signed [DATA_W-1:0] value_im;
        logic [NORM_W-1:0]        lhs_norm;
        logic [NORM_W-1:0]        rhs_norm;
    } t_in_beat;

    typedef struct packed {
        logic [FIELD_W-1:0]       out_row;
        logic [FIELD_W-1:0]       out_col;
        logic signed [DATA_W-1:0] result_re;
        logic signed [DATA_W-1:0] result_im;
        logic [NORM_W-1:0]        norm_out;
        logic                     last;
    } t_out_beat;

    typedef struct packed {
        logic signed [DATA_W-1:0] re;
        logic signed [DATA_W-1:0] im;
    } t_cplx;

    typedef enum logic [2:0] {
        OP_NONE = 3'd0,
        OP_RR   = 3'd1,
        OP_II   = 3'd2,
        OP_RI   = 3'd3,
        OP_IR   = 3'd4,
        OP_NORM = 3'd5
    } t_mac_op;

    typedef struct packed {
        t_mac_op op;
        logic    acc_clr;
    } t_mac_ctl;

    function automatic logic signed [DATA_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] t;
        logic signed [ACC_W-1:0] q;
        t = acc + ROUND_HALF;
        q = t >>> FRAC_BITS;
        if (q > SAT_HI) begin
            q = SAT_HI;
        end else if (q < SAT_LO) begin
            q = SAT_LO;
        end
        return q[DATA_W-1:0];
    endfunction

endpackage

/* hw/rtl/cmm_mac.sv */
// ----------------------------------------------------------------------------
// cmm_mac
// Shared multiplier with complex accumulators and norm saturation.
// ----------------------------------------------------------------------------
module cmm_mac (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cmm_pkg::t_mac_ctl                 i_ctl,
    input  cmm_pkg::t_cplx                    i_lhs,
    input  cmm_pkg::t_cplx                    i_rhs,
    input  logic [cmm_pkg::NORM_W-1:0]        i_lhs_norm,
    input  logic [cmm_pkg::NORM_W-1:0]        i_rhs_norm,
    output logic signed [cmm_pkg::DATA_W-1:0] o_re,
    output logic signed [cmm_pkg::DATA_W-1:0] o_im,
    output logic [cmm_pkg::NORM_W-1:0]        o_norm
);
    import cmm_pkg::*;

    logic signed [MUL_W-1:0]  w_a;
    logic signed [MUL_W-1:0]  w_b;
    logic signed [PROD_W-1:0] w_prod;
    logic signed [PROD_W-1:0] r_prod;
    t_mac_op                  r_op;
    logic signed [ACC_W-1:0]  r_acc_re;
    logic signed [ACC_W-1:0]  r_acc_im;
    logic signed [ACC_W-1:0]  w_term;
    logic [NORM_W-1:0]        r_norm;

    // operand select
    always_comb begin
        w_a = '0;
        w_b = '0;
        unique case (i_ctl.op)
            OP_RR: begin
                w_a = MUL_W'(i_lhs.re);
                w_b = MUL_W'(i_rhs.re);
            end
            OP_II: begin
                w_a = MUL_W'(i_lhs.im);
                w_b = MUL_W'(i_rhs.im);
            end
            OP_RI: begin
                w_a = MUL_W'(i_lhs.re);
                w_b = MUL_W'(i_rhs.im);
            end
            OP_IR: begin
                w_a = MUL_W'(i_lhs.im);
                w_b = MUL_W'(i_rhs.re);
            end
            OP_NORM: begin
                w_a = $signed({{(MUL_W - NORM_W){1'b0}}, i_lhs_norm});
                w_b = $signed({{(MUL_W - NORM_W){1'b0}}, i_rhs_norm});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;
    assign w_term = ACC_W'(r_prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_NONE;
        end else begin
            r_op <= i_ctl.op;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (i_ctl.acc_clr) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else begin
            unique case (r_op) inside
                OP_RR:        r_acc_re <= r_acc_re + w_term;
                OP_II:        r_acc_re <= r_acc_re - w_term;
                OP_RI, OP_IR: r_acc_im <= r_acc_im + w_term;
                default: ;
            endcase
        end
        if (r_op == OP_NORM) begin
            r_norm <= (r_prod[PROD_W-1:NORM_W] != '0) ? NORM_MAX : r_prod[NORM_W-1:0];
        end
    end

    assign o_re   = round_sat(r_acc_re);
    assign o_im   = round_sat(r_acc_im);
    assign o_norm = r_norm;

endmodule

/* hw/rtl/complex_matrix_multiply.sv */
// ----------------------------------------------------------------------------
// complex_matrix_multiply
// Square complex matrix product over stored left and right matrices.
// ----------------------------------------------------------------------------
// A load beat writes one element of the left or right store; loads outside
// the active side and func code 3 are dropped. A compute beat runs the
// product on one shared 21x21 multiplier: the norm product comes first, then
// each k term reads both stores and takes four multiply steps, and each
// element then drains and rounds, waiting there on any output stall. Input
// ready is low for the whole compute. The output register holds one result
// beat.
// ----------------------------------------------------------------------------
module complex_matrix_multiply #(
    parameter int MAX_QUBITS = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  cmm_pkg::t_in_beat             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output cmm_pkg::t_out_beat            o_out,
    input  logic                          i_cfg_we,
    input  logic [cmm_pkg::QC_W-1:0]      i_cfg_wdata
);
    import cmm_pkg::*;

    localparam int IW    = MAX_QUBITS;
    localparam int DEPTH = 1 << (2 * IW);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_NORM  = 6'b000010,
        S_ADDR  = 6'b000100,
        S_MUL   = 6'b001000,
        S_DRAIN = 6'b010000,
        S_RND   = 6'b100000
    } t_state;

    localparam logic [IW-1:0] ALL_ONES = '1;

    t_state                   r_state;
    logic [QC_W-1:0]          r_qc;
    logic [QC_W-1:0]          w_q;
    logic [IW-1:0]            w_last;
    logic [IW-1:0]            r_i;
    logic [IW-1:0]            r_j;
    logic [IW-1:0]            r_k;
    logic [1:0]               r_ph;
    logic [NORM_W-1:0]        r_lhs_norm;
    logic [NORM_W-1:0]        r_rhs_norm;
    logic                     r_ovld;
    t_out_beat                r_out;
    t_cplx                    r_lhs;
    t_cplx                    r_rhs;
    t_cplx                    mem_l [DEPTH];
    t_cplx                    mem_r [DEPTH];
    t_mac_ctl                 w_ctl;
    logic signed [DATA_W-1:0] w_re;
    logic signed [DATA_W-1:0] w_im;
    logic [NORM_W-1:0]        w_norm;
    logic                     w_in_acc;
    logic                     w_load_ok;
    logic                     w_out_load;
    logic [2*IW-1:0]          w_wr_addr;

    // active side clamp
    always_comb begin
        if (r_qc == '0) begin
            w_q = QC_W'(1);
        end else if (r_qc > QC_W'(MAX_QUBITS)) begin
            w_q = QC_W'(MAX_QUBITS);
        end else begin
            w_q = r_qc;
        end
    end

    assign w_last     = ALL_ONES >> (QC_W'(MAX_QUBITS) - w_q);
    assign o_in_ready = (r_state == S_IDLE);
    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_load_ok  = (i_in.row <= FIELD_W'(w_last)) && (i_in.col <= FIELD_W'(w_last));
    assign w_wr_addr  = {i_in.row[IW-1:0], i_in.col[IW-1:0]};
    assign w_out_load = (r_state == S_RND) && (!r_ovld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qc <= QC_W'(1);
        end else if (i_cfg_we) begin
            r_qc <= i_cfg_wdata;
        end
    end

    // element stores
    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_load_ok && i_in.func == FUNC_LOAD_L) begin
            mem_l[w_wr_addr] <= {i_in.value_re, i_in.value_im};
        end
        if (w_in_acc && w_load_ok && i_in.func == FUNC_LOAD_R) begin
            mem_r[w_wr_addr] <= {i_in.value_re, i_in.value_im};
        end
        r_lhs <= mem_l[{r_i, r_k}];
        r_rhs <= mem_r[{r_k, r_j}];
    end

    always_comb begin
        w_ctl.op      = OP_NONE;
        w_ctl.acc_clr = 1'b0;
        unique case (r_state)
            S_NORM: begin
                w_ctl.op      = OP_NORM;
                w_ctl.acc_clr = 1'b1;
            end
            S_MUL: begin
                case (r_ph)
                    2'd0:    w_ctl.op = OP_RR;
                    2'd1:    w_ctl.op = OP_II;
                    2'd2:    w_ctl.op = OP_RI;
                    default: w_ctl.op = OP_IR;
                endcase
            end
            S_RND:   w_ctl.acc_clr = w_out_load;
            default: ;
        endcase
    end

    cmm_mac u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_ctl),
        .i_lhs      (r_lhs),
        .i_rhs      (r_rhs),
        .i_lhs_norm (r_lhs_norm),
        .i_rhs_norm (r_rhs_norm),
        .o_re       (w_re),
        .o_im       (w_im),
        .o_norm     (w_norm)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_ph    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc && i_in.func == FUNC_COMPUTE) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_k     <= '0;
                        r_ph    <= '0;
                        r_state <= S_NORM;
                    end
                end
                S_NORM: r_state <= S_ADDR;
                S_ADDR: r_state <= S_MUL;
                S_MUL: begin
                    r_ph <= r_ph + 2'd1;
                    if (r_ph == 2'd3) begin
                        if (r_k == w_last) begin
                            r_k     <= '0;
                            r_state <= S_DRAIN;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_ADDR;
                        end
                    end
                end
                S_DRAIN: r_state <= S_RND;
                S_RND: begin
                    if (w_out_load) begin
                        if (r_j == w_last) begin
                            r_j <= '0;
                            if (r_i == w_last) begin
                                r_i     <= '0;
                                r_state <= S_IDLE;
                            end else begin
                                r_i     <= r_i + 1'b1;
                                r_state <= S_ADDR;
                            end
                        end else begin
                            r_j     <= r_j + 1'b1;
                            r_state <= S_ADDR;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && i_in.func == FUNC_COMPUTE) begin
            r_lhs_norm <= i_in.lhs_norm;
            r_rhs_norm <= i_in.rhs_norm;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld <= 1'b0;
        end else if (w_out_load) begin
            r_ovld <= 1'b1;
        end else if (i_out_ready) begin
            r_ovld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out.out_row   <= FIELD_W'(r_i);
            r_out.out_col   <= FIELD_W'(r_j);
            r_out.result_re <= w_re;
            r_out.result_im <= w_im;
            r_out.norm_out  <= w_norm;
            r_out.last      <= (r_i == w_last) && (r_j == w_last);
        end
    end

    assign o_out_valid = r_ovld;
    assign o_out       = r_out;

endmodule
